// ===== sv/mks_pkg.sv =====
// Shared types, constants, pattern lookup and microcode encoding for the Morse keying sequencer.
package mks_pkg;

    // Dit length reset value and derived dah length
    localparam logic [15:0] DIT_RESET = 16'd7000;
    localparam logic [17:0] DAH_RESET = 18'(DIT_RESET) * 18'd3;

    // Largest element count a pattern may carry
    localparam logic [2:0] MAX_ELEMS = 3'd5;

    // Input and result items
    typedef struct packed {
        logic [7:0] character;
        logic       message_end;
    } t_in_item;

    typedef struct packed {
        logic        key_on;
        logic [17:0] duration_ticks;
        logic        run_last;
    } t_out_item;

    // Microprogram counter
    typedef logic [2:0] t_pc;

    // Segment duration select
    typedef enum logic [1:0] {
        DUR_DIT,
        DUR_DAH,
        DUR_ELEM
    } t_dur_sel;

    // run_last select
    typedef enum logic [1:0] {
        LAST_NO,
        LAST_YES,
        LAST_NOT_END
    } t_last_sel;

    // Sequencing condition
    typedef enum logic [2:0] {
        COND_NONE,      // fall through to pc + 1
        COND_ALWAYS,    // jump to target
        COND_CNT_ZERO,  // jump to target (no segment) when no elements remain
        COND_END_CLR,   // finish when message_end is clear, else fall through
        COND_FINISH     // finish
    } t_cond;

    // One microcode control word
    typedef struct packed {
        logic      emit;
        logic      key_on;
        t_dur_sel  dur_sel;
        t_last_sel last_sel;
        logic      shift;
        t_cond     cond;
        t_pc       target;
    } t_uword;

    // Step controls passed from sequencer to datapath
    typedef struct packed {
        logic      load;
        logic      fire;
        logic      key_on;
        t_dur_sel  dur_sel;
        t_last_sel last_sel;
        logic      shift;
    } t_dp_ctrl;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic cnt_zero;
        logic end_flag;
        logic out_free;
    } t_dp_stat;

    // Microprogram addresses
    localparam t_pc PC_ELEM_ON  = 3'd0;
    localparam t_pc PC_ELEM_OFF = 3'd1;
    localparam t_pc PC_CHAR_GAP = 3'd2;
    localparam t_pc PC_END_GAP1 = 3'd3;
    localparam t_pc PC_END_GAP2 = 3'd4;

    // Packed pattern: count in [7:5], elements in [4:0], first in bit 4, 1 = dit
    function automatic logic [7:0] pattern_lookup(input logic [7:0] ch);
        logic [7:0] pat;
        pat = 8'h00;
        unique case (ch)
            "A": pat = 8'h50;  "B": pat = 8'h8E;  "C": pat = 8'h8A;  "D": pat = 8'h6C;
            "E": pat = 8'h30;  "F": pat = 8'h9A;  "G": pat = 8'h64;  "H": pat = 8'h9E;
            "I": pat = 8'h58;  "J": pat = 8'h90;  "K": pat = 8'h68;  "L": pat = 8'h96;
            "M": pat = 8'h40;  "N": pat = 8'h48;  "O": pat = 8'h60;  "P": pat = 8'h92;
            "Q": pat = 8'h84;  "R": pat = 8'h74;  "S": pat = 8'h7C;  "T": pat = 8'h20;
            "U": pat = 8'h78;  "V": pat = 8'h9C;  "W": pat = 8'h70;  "X": pat = 8'h8C;
            "Y": pat = 8'h88;  "Z": pat = 8'h86;
            "0": pat = 8'hA0;  "1": pat = 8'hB0;  "2": pat = 8'hB8;  "3": pat = 8'hBC;
            "4": pat = 8'hBE;  "5": pat = 8'hBF;  "6": pat = 8'hAF;  "7": pat = 8'hA7;
            "8": pat = 8'hA3;  "9": pat = 8'hA1;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

endpackage

// ===== sv/morse_keying_sequencer.sv =====
// Top level: microcoded Morse keying sequencer with step counter and jump logic.
//
// Input channel (i_in_valid / o_in_stall / i_in_item): one character byte and an
// end-of-message flag per item. Output channel (o_out_valid / i_out_stall /
// o_out_item): one keying segment per item, key on/off, duration in ticks, and
// run_last on the final segment of each character.
// Config: i_cfg_we writes i_cfg_data as the dit length in ticks; dah and the
// character gap are three dits. Write only while the block is idle.
// One character at a time: o_in_stall is high from acceptance until the last
// segment is loaded into the output register. The microprogram runs one step
// per cycle while the output register is free: 2 steps per element, 1 step for
// the empty-element check, 1 for the character gap and 2 more for the
// end-of-message gaps. A character may be accepted while the last segment
// of the previous one still waits in the output register.
// Output stall freezes the step counter; no segment is lost or repeated.
// Reset (synchronous, active low) idles the sequencer, empties the output
// register and restores the dit length to 7000 ticks.
module morse_keying_sequencer
    import mks_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item
);

    logic     r_busy;
    logic     n_busy;
    t_pc      r_pc;
    t_pc      n_pc;
    t_uword   uword;
    t_dp_ctrl ctrl;
    t_dp_stat stat;
    logic     step;
    logic     taken;
    logic     finish;
    logic     accept;

    mks_ucode_rom u_rom (
        .i_pc    (r_pc),
        .o_uword (uword)
    );

    mks_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_ctrl      (ctrl),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    assign accept     = i_in_valid && !r_busy;
    assign step       = r_busy && stat.out_free;
    assign o_in_stall = r_busy;

    // Condition evaluation, next pc and busy
    always_comb begin
        taken  = 1'b0;
        finish = 1'b0;
        unique case (uword.cond)
            COND_NONE:     taken = 1'b0;
            COND_ALWAYS:   taken = 1'b1;
            COND_CNT_ZERO: taken = stat.cnt_zero;
            COND_END_CLR:  finish = !stat.end_flag;
            COND_FINISH:   finish = 1'b1;
            default:       finish = 1'b1;
        endcase

        n_pc   = r_pc;
        n_busy = r_busy;
        if (accept) begin
            n_pc   = PC_ELEM_ON;
            n_busy = 1'b1;
        end else if (step) begin
            n_pc = taken ? uword.target : r_pc + t_pc'(1);
            if (finish) begin
                n_busy = 1'b0;
            end
        end

        // A taken empty-element jump emits nothing
        ctrl = '{load: accept,
                 fire: step && uword.emit && !(uword.cond == COND_CNT_ZERO && taken),
                 key_on: uword.key_on, dur_sel: uword.dur_sel,
                 last_sel: uword.last_sel, shift: uword.shift};
    end

    // Step counter and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= PC_ELEM_ON;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

endmodule

// ===== sv/mks_ucode_rom.sv =====
// Microprogram ROM: one control word per sequencer step.
module mks_ucode_rom
    import mks_pkg::*;
(
    input  t_pc    i_pc,
    output t_uword o_uword
);

    // Program: element on, element gap (loop), char gap, two end gaps
    always_comb begin
        unique case (i_pc)
            PC_ELEM_ON: begin
                o_uword = '{emit: 1'b1, key_on: 1'b1, dur_sel: DUR_ELEM,
                            last_sel: LAST_NO, shift: 1'b0,
                            cond: COND_CNT_ZERO, target: PC_CHAR_GAP};
            end
            PC_ELEM_OFF: begin
                o_uword = '{emit: 1'b1, key_on: 1'b0, dur_sel: DUR_DIT,
                            last_sel: LAST_NO, shift: 1'b1,
                            cond: COND_ALWAYS, target: PC_ELEM_ON};
            end
            PC_CHAR_GAP: begin
                o_uword = '{emit: 1'b1, key_on: 1'b0, dur_sel: DUR_DAH,
                            last_sel: LAST_NOT_END, shift: 1'b0,
                            cond: COND_END_CLR, target: PC_ELEM_ON};
            end
            PC_END_GAP1: begin
                o_uword = '{emit: 1'b1, key_on: 1'b0, dur_sel: DUR_DAH,
                            last_sel: LAST_NO, shift: 1'b0,
                            cond: COND_NONE, target: PC_ELEM_ON};
            end
            PC_END_GAP2: begin
                o_uword = '{emit: 1'b1, key_on: 1'b0, dur_sel: DUR_DAH,
                            last_sel: LAST_YES, shift: 1'b0,
                            cond: COND_FINISH, target: PC_ELEM_ON};
            end
            default: begin
                o_uword = '{emit: 1'b0, key_on: 1'b0, dur_sel: DUR_DIT,
                            last_sel: LAST_NO, shift: 1'b0,
                            cond: COND_FINISH, target: PC_ELEM_ON};
            end
        endcase
    end

endmodule

// ===== sv/mks_datapath.sv =====
// Datapath: dit/dah registers, element shift register and count, result output register.
module mks_datapath
    import mks_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  t_in_item  i_in_item,
    input  t_dp_ctrl  i_ctrl,
    output t_dp_stat  o_stat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic [15:0] r_dit;
    logic [17:0] r_dah;
    logic [4:0]  r_bits;
    logic [2:0]  r_cnt;
    logic        r_end;
    logic        r_out_valid;
    t_out_item   r_out_item;

    logic [7:0]  pat;
    logic [2:0]  pat_cnt;
    logic [17:0] dit_ext;
    logic [17:0] n_dur;
    logic        n_last;
    logic        out_free;

    assign dit_ext  = {2'b00, r_dit};
    assign pat      = pattern_lookup(i_in_item.character);
    assign pat_cnt  = (pat[7:5] > MAX_ELEMS) ? MAX_ELEMS : pat[7:5];
    assign out_free = !r_out_valid || !i_out_stall;

    // Dit length register; dah precomputed on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dit <= DIT_RESET;
            r_dah <= DAH_RESET;
        end else if (i_cfg_we) begin
            r_dit <= i_cfg_data;
            r_dah <= {1'b0, i_cfg_data, 1'b0} + {2'b00, i_cfg_data};
        end
    end

    // Element pattern: load on accept, shift out one element per gap
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_bits <= pat[4:0];
            r_cnt  <= pat_cnt;
            r_end  <= i_in_item.message_end;
        end else if (i_ctrl.fire && i_ctrl.shift) begin
            r_bits <= {r_bits[3:0], 1'b0};
            r_cnt  <= r_cnt - 3'd1;
        end
    end

    // Segment fields for this step
    always_comb begin
        unique case (i_ctrl.dur_sel)
            DUR_DIT:  n_dur = dit_ext;
            DUR_DAH:  n_dur = r_dah;
            DUR_ELEM: n_dur = r_bits[4] ? dit_ext : r_dah;
            default:  n_dur = dit_ext;
        endcase
        unique case (i_ctrl.last_sel)
            LAST_NO:      n_last = 1'b0;
            LAST_YES:     n_last = 1'b1;
            LAST_NOT_END: n_last = !r_end;
            default:      n_last = 1'b0;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.fire) begin
            r_out_item <= '{key_on: i_ctrl.key_on, duration_ticks: n_dur,
                            run_last: n_last};
        end
    end

    assign o_stat      = '{cnt_zero: (r_cnt == 3'd0), end_flag: r_end, out_free: out_free};
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== dv/morse_keying_sequencer_tb.sv =====
// Self-checking testbench for the Morse keying sequencer: directed and random characters.
module morse_keying_sequencer_tb;
    import mks_pkg::*;

    // Cycles without any accepted item before the run is declared hung
    localparam int WATCHDOG_LIMIT = 4000;
    // Receiver hold-off used to back the block up
    localparam int HOLD_CYCLES    = 150;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_PER_RUN = 85;

    // Packed Morse codes: count in [7:5], elements in [4:0] (first at bit 4, 1 = dit).
    // Entry for 'A' / '0' sits in the low byte.
    localparam logic [26*8-1:0] LETTER_CODES = {
        8'h86, 8'h88, 8'h8C, 8'h70, 8'h9C, 8'h78, 8'h20, 8'h7C, 8'h74, 8'h84,
        8'h92, 8'h60, 8'h48, 8'h40, 8'h96, 8'h68, 8'h90, 8'h58, 8'h9E, 8'h64,
        8'h9A, 8'h30, 8'h6C, 8'h8A, 8'h8E, 8'h50
    };
    localparam logic [10*8-1:0] DIGIT_CODES = {
        8'hA1, 8'hA3, 8'hA7, 8'hAF, 8'hBF, 8'hBE, 8'hBC, 8'hB8, 8'hB0, 8'hA0
    };

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_item  = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_item;

    // Testbench copy of the dit length register
    logic [15:0] dit_len = DIT_RESET;

    t_out_item   segments_due[$];
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    int          hold_req = 0;
    int          chars_sent = 0;
    int          segments_seen = 0;
    int          errors = 0;
    int          quiet_cycles = 0;

    morse_keying_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #6 i_clk = ~i_clk;

    // Expected keying run for one character at the current dit length
    task automatic queue_keying(input logic [7:0] ch, input logic fin);
        logic [7:0]  code;
        logic [17:0] dit18;
        logic [17:0] dah18;
        t_out_item   run[13];
        int          n;
        int          k;
        code  = 8'h00;
        dit18 = {2'b00, dit_len};
        dah18 = dit18 * 18'd3;
        k     = 0;
        if (ch >= "A" && ch <= "Z") begin
            code = LETTER_CODES[(int'(ch) - 65) * 8 +: 8];
        end else if (ch >= "0" && ch <= "9") begin
            code = DIGIT_CODES[(int'(ch) - 48) * 8 +: 8];
        end
        n = int'(code[7:5]);
        if (n > 5) n = 5;
        // element on, then one-dit gap
        for (int i = 0; i < n; i++) begin
            run[k] = '{key_on: 1'b1, duration_ticks: code[4 - i] ? dit18 : dah18,
                       run_last: 1'b0};
            k++;
            run[k] = '{key_on: 1'b0, duration_ticks: dit18, run_last: 1'b0};
            k++;
        end
        // character gap, plus two more at end of message
        run[k] = '{key_on: 1'b0, duration_ticks: dah18, run_last: 1'b0};
        k++;
        if (fin) begin
            for (int i = 0; i < 2; i++) begin
                run[k] = '{key_on: 1'b0, duration_ticks: dah18, run_last: 1'b0};
                k++;
            end
        end
        run[k - 1].run_last = 1'b1;
        for (int j = 0; j < k; j++) segments_due.push_back(run[j]);
    endtask

    // Offer one character and wait until the block takes it
    task automatic send_char(input logic [7:0] ch, input logic fin);
        int gap;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid            <= 1'b1;
        i_in_item.character   <= ch;
        i_in_item.message_end <= fin;
        do @(posedge i_clk); while (o_in_stall);
        queue_keying(ch, fin);
        chars_sent++;
    endtask

    // Stop offering and let every outstanding segment come out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (segments_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_dit_len(input logic [15:0] ticks);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= ticks;
        dit_len     = ticks;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Mostly coded letters and digits, some arbitrary bytes
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 8'(65 + $urandom_range(0, 25));
        if (r < 8) return 8'(48 + $urandom_range(0, 9));
        return 8'($urandom_range(0, 255));
    endfunction

    // Reset value of the dit length, before any write
    task automatic test_reset_dit();
        send_char("E", 1'b0);
        send_char("T", 1'b1);
        wait_drained();
    endtask

    // Every kind of character: all dits, all dahs, Q, uncoded bytes, field extremes
    task automatic test_code_table();
        set_dit_len(16'd5);
        send_char("A", 1'b0);
        send_char("Z", 1'b0);
        send_char("Q", 1'b0);
        send_char("5", 1'b0);
        send_char("0", 1'b1);
        send_char("9", 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        send_char("@", 1'b0);
        send_char("[", 1'b0);
        send_char("/", 1'b0);
        send_char(":", 1'b0);
        send_char("q", 1'b1);
        send_char(8'hC1, 1'b0);
        wait_drained();
    endtask

    // Largest, zero and one-tick dit lengths, with the longest runs
    task automatic test_dit_extremes();
        set_dit_len(16'hFFFF);
        send_char("0", 1'b1);
        send_char("H", 1'b0);
        set_dit_len(16'd0);
        send_char("Q", 1'b1);
        send_char("%", 1'b0);
        set_dit_len(16'd1);
        send_char("X", 1'b1);
        send_char("4", 1'b0);
        wait_drained();
    endtask

    // Receiver holds off while characters keep coming back to back
    task automatic test_backpressure();
        set_dit_len(16'd3);
        tx_idle  = 1'b0;
        hold_req = HOLD_CYCLES;
        for (int i = 0; i < 12; i++) send_char(pick_char(), 1'($urandom_range(0, 1)));
        wait_drained();
        tx_idle = 1'b1;
    endtask

    // Random characters over several dit lengths and idling mixes
    task automatic test_random_text();
        logic [15:0] lengths[4];
        lengths[0] = 16'($urandom_range(1, 20));
        lengths[1] = 16'hFFFF;
        lengths[2] = 16'($urandom_range(1, 65535));
        lengths[3] = 16'd1;
        for (int p = 0; p < 4; p++) begin
            set_dit_len(lengths[p]);
            tx_idle = (p == 0) || (p == 2);
            rx_idle = (p == 0) || (p == 3);
            for (int i = 0; i < RANDOM_PER_RUN; i++) begin
                send_char(pick_char(), $urandom_range(0, 3) == 0);
            end
        end
        wait_drained();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // Result side: per-item stall, plus the long hold-off when requested
    initial begin
        int gap;
        forever begin
            if (hold_req > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_req) @(posedge i_clk);
                hold_req = 0;
            end
            gap = rx_idle ? $urandom_range(0, 15) : 0;
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(i_rst_n && o_out_valid));
        end
    end

    // Compare each accepted segment with the oldest expected one
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            segments_seen++;
            if (segments_due.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("unexpected segment: key %0b ticks %0d last %0b",
                             o_out_item.key_on, o_out_item.duration_ticks,
                             o_out_item.run_last);
                end
            end else begin
                want = segments_due.pop_front();
                if (want.key_on !== o_out_item.key_on ||
                    want.duration_ticks !== o_out_item.duration_ticks ||
                    want.run_last !== o_out_item.run_last) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display({"segment %0d: expected key %0b ticks %0d last %0b, ",
                                  "got key %0b ticks %0d last %0b"},
                                 segments_seen, want.key_on, want.duration_ticks,
                                 want.run_last, o_out_item.key_on,
                                 o_out_item.duration_ticks, o_out_item.run_last);
                    end
                end
            end
        end
    end

    // Hang detection
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_dit();
        test_code_table();
        test_dit_extremes();
        test_backpressure();
        test_random_text();
        repeat (20) @(posedge i_clk);
        if (segments_due.size() != 0) begin
            $display("%0d expected segments never arrived", segments_due.size());
            errors++;
        end
        $display("ran %0d characters, %0d keying segments checked", chars_sent, segments_seen);
        $display("dit lengths 0, 1 and 65535 included, with back-pressure and random idling");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
